// ----- rtl/core/neuron_dot_product_activation_defines.svh -----
// Assertion macros used by the checker file.
`ifndef NEURON_DOT_PRODUCT_ACTIVATION_DEFINES_SVH
`define NEURON_DOT_PRODUCT_ACTIVATION_DEFINES_SVH

// Same-cycle implication.
`define NDPA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NDPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ndpa_pkg.sv -----
package ndpa_pkg;

  localparam int DATA_W    = 16;
  localparam int FRAC_BITS = 12;
  localparam int ACC_W     = 40;
  localparam int OUT_W     = 16;
  localparam int MODE_W    = 2;

  // Evaluation works in unsigned Q.30
  localparam int Q      = 30;
  localparam int QW     = Q + 1;
  localparam int PW     = 2 * QW;
  localparam int DEN_W  = QW + 1;
  localparam int CNT_W  = 6;
  localparam int KW     = 5;
  localparam int SER_TERMS = 17;
  localparam int ALIGN  = Q - 2 * FRAC_BITS;
  localparam int CLAMP_W = 2 * FRAC_BITS + 6;
  localparam int AQ_W   = Q + CNT_W;

  localparam logic [QW-1:0]    QONE    = QW'(1) << Q;
  localparam logic [PW-1:0]    QHALF   = PW'(1) << (Q - 1);
  localparam logic [ACC_W-1:0] MAG_LIM = ACC_W'(32) << (2 * FRAC_BITS);

  localparam logic [MODE_W-1:0] MODE_SIG   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DSIG  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TANH  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DTANH = 2'd3;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic             start;
    logic [PW-1:0]    num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [PW-1:0] quo;
  } div_rsp_t;

  function automatic acc_t sat_add(acc_t a, acc_t b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

// ----- rtl/core/ndpa_if.sv -----
interface ndpa_in_if import ndpa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] in_value;
  logic signed [DATA_W-1:0] weight;
  logic signed [DATA_W-1:0] bias;
  logic                     last_term;

  modport source (output valid, in_value, weight, bias, last_term, input ready);
  modport sink (input valid, in_value, weight, bias, last_term, output ready);
endinterface

interface ndpa_out_if import ndpa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] activation;

  modport source (output valid, activation, input ready);
  modport sink (input valid, activation, output ready);
endinterface

// ----- rtl/core/neuron_dot_product_activation.sv -----
// Neuron with dot product and activation. The front takes one term per cycle and
// multiply-accumulates it into a saturating Q16.24 sum; a last term adds the bias and
// hands the sum through a two-entry queue to the back, which evaluates the selected
// function (sigmoid, its derivative, tanh, sech squared) and returns one Q2.14 item.
// The back runs one shared 31x31 multiplier and a radix-2 divider. Two 17-term
// exp series, one power of exp(-1) per whole unit of the sum's magnitude (up to 32,
// each a multiply in S_POW and a rounding in S_POW_RND) and the final division lead
// from the pop to the result register; tanh adds the squaring of exp (S_E2_MUL,
// S_E2_RND) and either derivative a multiply (S_MUL2), so a result takes longer for
// larger magnitudes and for those functions. The front only stalls when the queue
// holds two sums not yet taken by the back.
module neuron_dot_product_activation import ndpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [MODE_W-1:0] cfg_wdata_i,
  ndpa_in_if.sink           in_i,
  ndpa_out_if.source        out_o
);

  logic [MODE_W-1:0] mode_q;
  logic              full, push, pop, qvalid;
  acc_t              push_sum, q_sum;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SIG;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  ndpa_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .sum_o  (push_sum)
  );

  ndpa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_sum),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (qvalid),
    .data_o  (q_sum)
  );

  ndpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ndpa_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_i    (mode_q),
    .valid_i   (qvalid),
    .sum_i     (q_sum),
    .pop_o     (pop),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp),
    .out_o     (out_o)
  );

endmodule

// ----- rtl/core/ndpa_front.sv -----
module ndpa_front import ndpa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ndpa_in_if.sink    in_i,
  input  logic       full_i,
  output logic       push_o,
  output acc_t       sum_o
);

  acc_t acc_q, acc_d;
  acc_t prod_ext, bias_ext, s1, s2;
  logic signed [2*DATA_W-1:0] prod;
  logic accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  always_comb begin
    prod     = in_i.in_value * in_i.weight;
    prod_ext = ACC_W'(prod);
    bias_ext = ACC_W'(in_i.bias) <<< FRAC_BITS;
    s1       = sat_add(acc_q, prod_ext);
    s2       = sat_add(s1, bias_ext);
    acc_d    = acc_q;
    if (accept) begin
      acc_d = in_i.last_term ? '0 : s1;
    end
  end

  assign push_o = accept && in_i.last_term;
  assign sum_o  = s2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

// ----- rtl/core/ndpa_fifo.sv -----
module ndpa_fifo import ndpa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  acc_t data_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output acc_t data_o
);

  acc_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ----- rtl/core/ndpa_div.sv -----
module ndpa_div import ndpa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DEN_W:0]   rem_q;
  logic [PW-1:0]    quo_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q;
  logic [DEN_W:0]   rem_sh;
  logic             fit;

  // Restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q[DEN_W-1:0], quo_q[PW-1]};
    fit    = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (run_q) begin
      rem_q <= fit ? rem_sh - {1'b0, den_q} : rem_sh;
      quo_q <= {quo_q[PW-2:0], fit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(PW - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ----- rtl/core/ndpa_back.sv -----
module ndpa_back import ndpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [MODE_W-1:0] mode_i,
  input  logic              valid_i,
  input  acc_t              sum_i,
  output logic              pop_o,
  output div_req_t          div_req_o,
  input  div_rsp_t          div_rsp_i,
  ndpa_out_if.source        out_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SER_MUL = 4'd1;
  localparam logic [3:0] S_SER_DIV = 4'd2;
  localparam logic [3:0] S_SER_WT  = 4'd3;
  localparam logic [3:0] S_POW     = 4'd4;
  localparam logic [3:0] S_POW_RND = 4'd5;
  localparam logic [3:0] S_E_RND   = 4'd6;
  localparam logic [3:0] S_E2_MUL  = 4'd7;
  localparam logic [3:0] S_E2_RND  = 4'd8;
  localparam logic [3:0] S_TQ_DIV  = 4'd9;
  localparam logic [3:0] S_TQ_WT   = 4'd10;
  localparam logic [3:0] S_MUL2    = 4'd11;
  localparam logic [3:0] S_FIN     = 4'd12;
  localparam logic [3:0] S_OUT     = 4'd13;

  logic [3:0]       state_q, state_d;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [QW-1:0]    fx_q, f_q, term_q, em1_q, ef_q, ep_q, e_q, qt_q;
  logic [QW:0]      ssum_q;
  logic [KW-1:0]    k_q;
  logic             sel_q;
  logic [PW-1:0]    p_q;
  logic [OUT_W-1:0] res_q, act_q;
  logic             ovalid_q;

  logic [ACC_W-1:0] mag, clamped;
  logic [AQ_W-1:0]  a_q30;
  logic [QW:0]      ssum_nx;
  logic [QW-1:0]    rnd_p, qv;
  logic [QW:0]      qv_r;
  logic [PW-1:0]    fin_s;
  logic [DEN_W-1:0] tq_den;
  logic [PW-1:0]    tq_num;
  logic             out_free;
  logic [QW-1:0]    mul_a, mul_b;
  logic [PW-1:0]    mul_p;

  assign out_free = !ovalid_q || out_o.ready;
  assign pop_o    = (state_q == S_IDLE) && valid_i;

  always_comb begin
    mag     = sum_i[ACC_W-1] ? ACC_W'(0) - ACC_W'(sum_i) : ACC_W'(sum_i);
    clamped = (mag > MAG_LIM) ? MAG_LIM : mag;
    a_q30   = AQ_W'(clamped[CLAMP_W-1:0]) << ALIGN;
    ssum_nx = k_q[0] ? ssum_q - {1'b0, div_rsp_i.quo[QW-1:0]}
                     : ssum_q + {1'b0, div_rsp_i.quo[QW-1:0]};
    rnd_p   = QW'((p_q + QHALF) >> Q);
    tq_den  = DEN_W'(QONE) + DEN_W'(e_q);
    if (mode_i[1]) begin
      tq_num = (PW'(QONE - e_q) << Q) + PW'(tq_den >> 1);
    end else begin
      tq_num = (PW'(e_q) << Q) + PW'(tq_den >> 1);
    end
    qv      = (mode_i == MODE_SIG && !neg_q) ? QONE - qt_q : qt_q;
    qv_r    = ({1'b0, qv} + (QW+1)'(1 << 15)) >> 16;
    if (mode_i == MODE_DSIG) begin
      fin_s = p_q + (PW'(1) << 45);
    end else begin
      fin_s = (PW'(1) << 60) - p_q + (PW'(1) << 45);
    end
  end

  // pick the operands of the one multiplier by state
  always_comb begin
    mul_a = term_q;
    mul_b = fx_q;
    case (state_q)
      S_POW: begin
        mul_a = ep_q;
        mul_b = (cnt_q != '0) ? em1_q : ef_q;
      end
      S_E2_MUL: begin
        mul_a = e_q;
        mul_b = e_q;
      end
      S_MUL2: begin
        mul_a = qt_q;
        mul_b = mode_i[1] ? qt_q : QONE - qt_q;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    div_req_o.start = (state_q == S_SER_DIV) || (state_q == S_TQ_DIV);
    div_req_o.num   = (state_q == S_SER_DIV) ? PW'(p_q[PW-1:Q]) : tq_num;
    div_req_o.den   = (state_q == S_SER_DIV) ? DEN_W'(k_q) : tq_den;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (valid_i) state_d = S_SER_MUL;
      S_SER_MUL: state_d = S_SER_DIV;
      S_SER_DIV: state_d = S_SER_WT;
      S_SER_WT: begin
        if (div_rsp_i.done) begin
          state_d = (k_q == KW'(SER_TERMS) && sel_q) ? S_POW : S_SER_MUL;
        end
      end
      S_POW:     state_d = (cnt_q != '0) ? S_POW_RND : S_E_RND;
      S_POW_RND: state_d = S_POW;
      S_E_RND:   state_d = mode_i[1] ? S_E2_MUL : S_TQ_DIV;
      S_E2_MUL:  state_d = S_E2_RND;
      S_E2_RND:  state_d = S_TQ_DIV;
      S_TQ_DIV:  state_d = S_TQ_WT;
      S_TQ_WT: begin
        if (div_rsp_i.done) begin
          state_d = mode_i[0] ? S_MUL2 : S_FIN;
        end
      end
      S_MUL2:    state_d = S_FIN;
      S_FIN:     state_d = S_OUT;
      S_OUT:     if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        neg_q  <= sum_i[ACC_W-1];
        cnt_q  <= a_q30[AQ_W-1:Q];
        f_q    <= QW'(a_q30[Q-1:0]);
        fx_q   <= QONE;
        term_q <= QONE;
        ssum_q <= {1'b0, QONE};
        k_q    <= KW'(1);
        sel_q  <= 1'b0;
      end
      S_SER_MUL: p_q <= mul_p;
      S_SER_WT: begin
        if (div_rsp_i.done) begin
          term_q <= div_rsp_i.quo[QW-1:0];
          ssum_q <= ssum_nx;
          k_q    <= k_q + 1'b1;
          if (k_q == KW'(SER_TERMS)) begin
            // first pass gives exp(-1), second exp(-frac)
            if (!sel_q) begin
              em1_q  <= ssum_nx[QW-1:0];
              fx_q   <= f_q;
              term_q <= QONE;
              ssum_q <= {1'b0, QONE};
              k_q    <= KW'(1);
              sel_q  <= 1'b1;
            end else begin
              ef_q <= ssum_nx[QW-1:0];
              ep_q <= QONE;
            end
          end
        end
      end
      S_POW: begin
        p_q <= mul_p;
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
      S_POW_RND: ep_q <= rnd_p;
      S_E_RND:   e_q  <= rnd_p;
      S_E2_MUL:  p_q  <= mul_p;
      S_E2_RND:  e_q  <= rnd_p;
      S_TQ_WT:   if (div_rsp_i.done) qt_q <= div_rsp_i.quo[QW-1:0];
      S_MUL2:    p_q  <= mul_p;
      S_FIN: begin
        if (mode_i[0]) begin
          res_q <= fin_s[PW-1:46];
        end else if (mode_i == MODE_TANH && neg_q) begin
          res_q <= OUT_W'(0) - OUT_W'(qv_r);
        end else begin
          res_q <= OUT_W'(qv_r);
        end
      end
      S_OUT:     if (out_free) act_q <= res_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.activation = act_q;

endmodule

// ----- rtl/core/ndpa_checker.sv -----
`include "neuron_dot_product_activation_defines.svh"

module ndpa_checker import ndpa_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    cfg_we_i,
  input logic [MODE_W-1:0]       cfg_wdata_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [OUT_W-1:0] out_act_i
);

  logic [MODE_W-1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SIG;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  `NDPA_ASSERT_NEXT(a_hold_valid, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "item dropped while stalled")
  `NDPA_ASSERT_NEXT(a_hold_data, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_act_i), "item changed while stalled")
  `NDPA_ASSERT_NOW(a_range, clk_i, rst_ni, out_valid_i, out_act_i >= -16384 && out_act_i <= 16384, "activation out of range")
  `NDPA_ASSERT_NOW(a_dsig, clk_i, rst_ni, out_valid_i && mode_q == MODE_DSIG, out_act_i >= 0 && out_act_i <= 4096, "sigmoid derivative out of range")

endmodule

bind neuron_dot_product_activation ndpa_checker u_ndpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_act_i   (out_o.activation)
);
